// File: rtl/cpts_pkg.sv
// ----------------------------------------------------------------------------
// cpts_pkg: shared types and codes of the task scheduler
// Request codes, status codes, task state encoding and default sizes.
// ----------------------------------------------------------------------------
package cpts_pkg;

	// default number of task slots
	localparam int unsigned MAX_TASKS_DEF = 16;

	// tick register
	localparam int unsigned       TICK_W     = 10;
	localparam logic [TICK_W-1:0] TICK_RESET = 10'd10;

	// request codes
	localparam logic [3:0] REQ_CREATE   = 4'd0;
	localparam logic [3:0] REQ_DELETE   = 4'd1;
	localparam logic [3:0] REQ_DELAY    = 4'd2;
	localparam logic [3:0] REQ_SUSPEND  = 4'd3;
	localparam logic [3:0] REQ_RESUME   = 4'd4;
	localparam logic [3:0] REQ_SETPRIO  = 4'd5;
	localparam logic [3:0] REQ_PEND     = 4'd6;
	localparam logic [3:0] REQ_TICK     = 4'd7;
	localparam logic [3:0] REQ_SCHED    = 4'd8;
	localparam logic [3:0] REQ_FINISH   = 4'd9;
	localparam logic [3:0] REQ_QUERY    = 4'd10;

	// status codes
	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_EXISTS     = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND  = 2'd2;
	localparam logic [1:0] STAT_NONE_READY = 2'd3;

	// task state encoding
	typedef enum logic [2:0] {
		TS_TERM  = 3'd0,
		TS_READY = 3'd1,
		TS_RUN   = 3'd2,
		TS_DELAY = 3'd3,
		TS_SUSP  = 3'd4,
		TS_PEND  = 3'd5
	} tstate_t;

endpackage

// File: rtl/cpts_tick_unit.sv
// ----------------------------------------------------------------------------
// cpts_tick_unit: delay countdown of one task slot
// Counts a delayed slot down by one tick without wrapping, and wakes it
// once the delay has already reached zero.
// ----------------------------------------------------------------------------
module cpts_tick_unit (
	input  cpts_pkg::tstate_t                cur_state,
	input  logic [31:0]                      cur_delay,
	input  logic [cpts_pkg::TICK_W-1:0]      tick,
	output cpts_pkg::tstate_t                nxt_state,
	output logic [31:0]                      nxt_delay
);
	import cpts_pkg::*;

	logic [31:0] tick_w;

	assign tick_w = 32'(tick);

	// saturating countdown, wake on zero
	always_comb begin
		nxt_state = cur_state;
		nxt_delay = cur_delay;
		if (cur_state == TS_DELAY) begin
			if (cur_delay == 32'd0) begin
				nxt_state = TS_READY;
			end else if (cur_delay > tick_w) begin
				nxt_delay = cur_delay - tick_w;
			end else begin
				nxt_delay = 32'd0;
			end
		end
	end

endmodule

// File: rtl/cooperative_priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// cooperative_priority_task_scheduler: priority round-robin task scheduler
// Task slots with state, priority, delay and run peak, kept in a list
// ordered by priority and walked one entry at a time by a small sequencer.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result beat
// appears on the result ports for a single cycle with done high, and cannot
// be stalled. A list walk visits one list entry at a time (S_RD fetches the
// entry, then S_EL updates the slot through the shared slot port and tick
// unit). Create, delete, tick and schedule walk the list at most once, and
// set priority and finish, which remove and reinsert the slot, at most
// twice. Reset is immediate: the order list needs no clearing pass.
module cooperative_priority_task_scheduler #(
	parameter int unsigned MAX_TASKS = cpts_pkg::MAX_TASKS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [3:0]                        req_type,
	input  logic [3:0]                        slot,
	input  logic [7:0]                        priority_req,
	input  logic [31:0]                       delay_ms,
	input  logic [15:0]                       msg_waiting,
	input  logic                              tick_ms_we,
	input  logic [cpts_pkg::TICK_W-1:0]       tick_ms,
	output logic                              done,
	output logic [1:0]                        status,
	output logic                              grant_valid,
	output logic [3:0]                        granted_slot,
	output logic [2:0]                        task_state,
	output logic [7:0]                        task_priority,
	output logic [15:0]                       run_peak_ms
);
	import cpts_pkg::*;

	localparam int unsigned    SW      = $clog2(MAX_TASKS);
	localparam int unsigned    CW      = $clog2(MAX_TASKS + 1);
	localparam logic [CW-1:0]  CNT_MAX = CW'(MAX_TASKS);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_EXEC   = 5'b00010,
		S_RD     = 5'b00100,
		S_EL     = 5'b01000,
		S_REPORT = 5'b10000
	} fsm_t;

	typedef enum logic [1:0] {
		M_REM   = 2'd0,
		M_INS   = 2'd1,
		M_TICK  = 2'd2,
		M_SCHED = 2'd3
	} mode_t;

	// sequencer
	fsm_t            fsm_q;
	mode_t           mode_q;
	logic            ins_after_q;
	logic [CW-1:0]   i_q;
	logic [SW-1:0]   e_q;
	logic [SW-1:0]   s_q;
	logic [SW-1:0]   carry_q;
	logic            found_q;
	logic [7:0]      ps_q;
	logic [1:0]      st_q;
	logic            grant_q;
	logic [SW-1:0]   gslot_q;

	// latched request
	logic [3:0]      req_q;
	logic [3:0]      slot_q;
	logic [7:0]      prio_q;
	logic [31:0]     dly_q;
	logic [15:0]     msg_q;

	// scheduler state
	logic [TICK_W-1:0] tick_q;
	logic [CW-1:0]   cnt_q;
	logic [SW-1:0]   rs_q;
	logic            rv_q;
	logic [15:0]     run_time_q;
	tstate_t         state_q [MAX_TASKS];
	logic [7:0]      sprio_q [MAX_TASKS];
	logic [31:0]     delay_q [MAX_TASKS];
	logic [15:0]     peak_q  [MAX_TASKS];
	logic [MAX_TASKS-1:0] inl_q;
	logic [SW-1:0]   ol_q    [MAX_TASKS];

	// result beat
	logic            done_q;
	logic [1:0]      status_q;
	logic            grant_valid_q;
	logic [3:0]      granted_slot_q;
	logic [2:0]      task_state_q;
	logic [7:0]      task_priority_q;
	logic [15:0]     run_peak_q;

	// combinational
	logic [SW+3:0]   slot_ext;
	logic [SW+3:0]   gslot_ext;
	logic [SW-1:0]   slot_t;
	logic            in_range;
	logic            uses_run;
	logic [SW-1:0]   t_idx;
	logic            rep_ok;
	logic [SW-1:0]   aidx;
	tstate_t         a_state;
	logic [7:0]      a_prio;
	logic [31:0]     a_delay;
	logic [15:0]     a_peak;
	logic            a_inl;
	logic [SW-1:0]   ol_rd;
	logic [CW-1:0]   i_m1;
	logic [CW-1:0]   cnt_after_rem;
	logic [63:0]     msg_w;
	logic            has_msg;
	logic            elig;
	logic            ins_here;
	logic            scan_end;
	tstate_t         tk_state;
	logic [31:0]     tk_delay;

	// request decode
	assign slot_ext  = {{SW{1'b0}}, slot_q};
	assign slot_t    = slot_ext[SW-1:0];
	assign in_range  = 8'(slot_q) < 8'(MAX_TASKS);
	assign uses_run  = (req_q == REQ_PEND) || (req_q == REQ_SCHED) || (req_q == REQ_FINISH);
	assign t_idx     = uses_run ? rs_q : slot_t;
	assign rep_ok    = uses_run ? rv_q : in_range;

	// single slot port address
	always_comb begin
		unique case (fsm_q)
			S_EL:    aidx = e_q;
			S_RD:    aidx = s_q;
			default: aidx = t_idx;
		endcase
	end

	assign a_state = state_q[aidx];
	assign a_prio  = sprio_q[aidx];
	assign a_delay = delay_q[aidx];
	assign a_peak  = peak_q[aidx];
	assign a_inl   = inl_q[aidx];

	// list walk helpers
	assign ol_rd         = ol_q[i_q[SW-1:0]];
	assign i_m1          = i_q - 1'b1;
	assign cnt_after_rem = cnt_q - CW'(found_q);
	assign scan_end      = (i_q == cnt_q);
	assign msg_w         = 64'(msg_q);
	assign has_msg       = msg_w[6'(e_q)];
	assign elig          = (a_state == TS_READY) || (a_state == TS_RUN) ||
	                       ((a_state == TS_PEND) && has_msg);
	assign ins_here      = !found_q && (a_prio > ps_q);

	cpts_tick_unit u_tick (
		.cur_state (a_state),
		.cur_delay (a_delay),
		.tick      (tick_q),
		.nxt_state (tk_state),
		.nxt_delay (tk_delay)
	);

	// latch the request beat
	always_ff @(posedge clk) begin
		if (fsm_q == S_IDLE && start) begin
			req_q  <= req_type;
			slot_q <= slot;
			prio_q <= priority_req;
			dly_q  <= delay_ms;
			msg_q  <= msg_waiting;
		end
	end

	// order list shifting
	always_ff @(posedge clk) begin
		if (fsm_q == S_EL && mode_q == M_REM && found_q) begin
			ol_q[i_m1[SW-1:0]] <= e_q;
		end else if (fsm_q == S_EL && mode_q == M_INS) begin
			if (ins_here) begin
				ol_q[i_q[SW-1:0]] <= s_q;
			end else if (found_q) begin
				ol_q[i_q[SW-1:0]] <= carry_q;
			end
		end else if (fsm_q == S_RD && scan_end && mode_q == M_INS) begin
			ol_q[cnt_q[SW-1:0]] <= found_q ? carry_q : s_q;
		end
	end

	// sequencer and slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= S_IDLE;
			mode_q      <= M_REM;
			ins_after_q <= 1'b0;
			i_q         <= '0;
			e_q         <= '0;
			s_q         <= '0;
			carry_q     <= '0;
			found_q     <= 1'b0;
			ps_q        <= '0;
			st_q        <= STAT_OK;
			grant_q     <= 1'b0;
			gslot_q     <= '0;
			tick_q      <= TICK_RESET;
			cnt_q       <= '0;
			rs_q        <= '0;
			rv_q        <= 1'b0;
			run_time_q  <= '0;
			inl_q       <= '0;
			done_q      <= 1'b0;
			for (int k = 0; k < MAX_TASKS; k++) begin
				state_q[k] <= TS_TERM;
				sprio_q[k] <= '0;
				delay_q[k] <= '0;
				peak_q[k]  <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (tick_ms_we) begin
				tick_q <= tick_ms;
			end
			unique case (fsm_q)
				S_IDLE: begin
					if (start) begin
						fsm_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					st_q        <= STAT_OK;
					grant_q     <= 1'b0;
					gslot_q     <= '0;
					i_q         <= '0;
					found_q     <= 1'b0;
					s_q         <= t_idx;
					ps_q        <= prio_q;
					ins_after_q <= 1'b0;
					fsm_q       <= S_REPORT;
					unique case (req_q)
						REQ_CREATE: begin
							if (!in_range) begin
								st_q <= STAT_NOT_FOUND;
							end else if (a_inl) begin
								st_q <= STAT_EXISTS;
							end else begin
								delay_q[aidx] <= '0;
								state_q[aidx] <= TS_READY;
								sprio_q[aidx] <= prio_q;
								if (cnt_q < CNT_MAX) begin
									mode_q <= M_INS;
									fsm_q  <= S_RD;
								end
							end
						end
						REQ_DELETE: begin
							if (!in_range) begin
								st_q <= STAT_NOT_FOUND;
							end else begin
								state_q[aidx] <= TS_TERM;
								if (a_inl) begin
									mode_q <= M_REM;
									fsm_q  <= S_RD;
								end else begin
									st_q <= STAT_NOT_FOUND;
								end
							end
						end
						REQ_DELAY, REQ_SUSPEND, REQ_RESUME, REQ_SETPRIO: begin
							if (!in_range || a_state == TS_TERM) begin
								st_q <= STAT_NOT_FOUND;
							end else begin
								priority if (req_q == REQ_DELAY) begin
									delay_q[aidx] <= dly_q;
									state_q[aidx] <= TS_DELAY;
								end else if (req_q == REQ_SUSPEND) begin
									state_q[aidx] <= TS_SUSP;
								end else if (req_q == REQ_RESUME) begin
									state_q[aidx] <= TS_READY;
								end else begin
									sprio_q[aidx] <= prio_q;
									mode_q        <= M_REM;
									ins_after_q   <= 1'b1;
									fsm_q         <= S_RD;
								end
							end
						end
						REQ_PEND: begin
							if (!rv_q || a_state == TS_TERM) begin
								st_q <= STAT_NOT_FOUND;
							end else begin
								state_q[aidx] <= TS_PEND;
							end
						end
						REQ_TICK: begin
							if (rv_q) begin
								run_time_q <= run_time_q + 16'(tick_q);
							end
							mode_q <= M_TICK;
							fsm_q  <= S_RD;
						end
						REQ_SCHED: begin
							rv_q   <= 1'b0;
							st_q   <= STAT_NONE_READY;
							mode_q <= M_SCHED;
							fsm_q  <= S_RD;
						end
						REQ_FINISH: begin
							if (!rv_q) begin
								st_q <= STAT_NOT_FOUND;
							end else begin
								if (run_time_q > a_peak) begin
									peak_q[aidx] <= run_time_q;
								end
								if (a_state == TS_RUN) begin
									state_q[aidx] <= TS_READY;
								end
								if (a_state != TS_TERM) begin
									ps_q        <= a_prio;
									mode_q      <= M_REM;
									ins_after_q <= 1'b1;
									fsm_q       <= S_RD;
								end
							end
						end
						REQ_QUERY: begin
							if (!in_range) begin
								st_q <= STAT_NOT_FOUND;
							end
						end
						default: begin
						end
					endcase
				end
				S_RD: begin
					if (scan_end) begin
						unique case (mode_q)
							M_REM: begin
								inl_q[aidx] <= 1'b0;
								cnt_q       <= cnt_after_rem;
								if (ins_after_q && cnt_after_rem < CNT_MAX) begin
									mode_q  <= M_INS;
									i_q     <= '0;
									found_q <= 1'b0;
								end else begin
									fsm_q <= S_REPORT;
								end
							end
							M_INS: begin
								inl_q[aidx] <= 1'b1;
								cnt_q       <= cnt_q + 1'b1;
								fsm_q       <= S_REPORT;
							end
							default: begin
								fsm_q <= S_REPORT;
							end
						endcase
					end else begin
						e_q   <= ol_rd;
						fsm_q <= S_EL;
					end
				end
				S_EL: begin
					i_q   <= i_q + 1'b1;
					fsm_q <= S_RD;
					unique case (mode_q)
						M_REM: begin
							if (!found_q && e_q == s_q) begin
								found_q <= 1'b1;
							end
						end
						M_INS: begin
							if (ins_here) begin
								found_q <= 1'b1;
								carry_q <= e_q;
							end else if (found_q) begin
								carry_q <= e_q;
							end
						end
						M_TICK: begin
							state_q[aidx] <= tk_state;
							delay_q[aidx] <= tk_delay;
						end
						M_SCHED: begin
							if (elig) begin
								state_q[aidx] <= TS_RUN;
								run_time_q    <= '0;
								rs_q          <= e_q;
								rv_q          <= 1'b1;
								st_q          <= STAT_OK;
								grant_q       <= 1'b1;
								gslot_q       <= e_q;
								fsm_q         <= S_REPORT;
							end
						end
					endcase
				end
				S_REPORT: begin
					done_q <= 1'b1;
					fsm_q  <= S_IDLE;
				end
				default: begin
					fsm_q <= S_IDLE;
				end
			endcase
		end
	end

	// result beat payload
	assign gslot_ext = {4'b0, gslot_q};

	always_ff @(posedge clk) begin
		if (fsm_q == S_REPORT) begin
			status_q        <= st_q;
			grant_valid_q   <= grant_q;
			granted_slot_q  <= gslot_ext[3:0];
			task_state_q    <= rep_ok ? a_state : TS_TERM;
			task_priority_q <= rep_ok ? a_prio : 8'd0;
			run_peak_q      <= rep_ok ? a_peak : 16'd0;
		end
	end

	assign busy          = (fsm_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign grant_valid   = grant_valid_q;
	assign granted_slot  = granted_slot_q;
	assign task_state    = task_state_q;
	assign task_priority = task_priority_q;
	assign run_peak_ms   = run_peak_q;

`ifndef SYNTHESIS
	// list never holds more entries than slots
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("order list count exceeds slot count");

	// a result beat follows the report step only
	a_done_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(fsm_q == S_REPORT))
		else $error("result beat without report step");

	// an accepted request makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// a grant always reports ok and leaves a running slot
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && grant_valid_q) |-> (status_q == STAT_OK && rv_q))
		else $error("grant without ok status or running slot");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: task scheduler request checker
// Random and directed requests go into the scheduler one beat at a time; a
// behavioral copy of the slot table and order list predicts each answer beat.
// ----------------------------------------------------------------------------
module testbench;
	import cpts_pkg::*;

	localparam int unsigned NSLOT     = 16;
	localparam int unsigned CYC_LIMIT = 600000;

	typedef struct packed {
		logic [3:0]  req;
		logic [3:0]  slt;
		logic [7:0]  prio;
		logic [31:0] dly;
		logic [15:0] msg;
	} req_beat_t;

	typedef struct packed {
		logic [1:0]  stat;
		logic        gv;
		logic [3:0]  gs;
		logic [2:0]  st;
		logic [7:0]  pr;
		logic [15:0] peak;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [3:0]  req_type;
	logic [3:0]  slot;
	logic [7:0]  priority_req;
	logic [31:0] delay_ms;
	logic [15:0] msg_waiting;
	logic        tick_ms_we;
	logic [9:0]  tick_ms;
	logic        done;
	logic [1:0]  status;
	logic        grant_valid;
	logic [3:0]  granted_slot;
	logic [2:0]  task_state;
	logic [7:0]  task_priority;
	logic [15:0] run_peak_ms;

	cooperative_priority_task_scheduler dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .slot(slot), .priority_req(priority_req),
		.delay_ms(delay_ms), .msg_waiting(msg_waiting),
		.tick_ms_we(tick_ms_we), .tick_ms(tick_ms), .done(done),
		.status(status), .grant_valid(grant_valid), .granted_slot(granted_slot),
		.task_state(task_state), .task_priority(task_priority),
		.run_peak_ms(run_peak_ms)
	);

	// scheduler shadow state
	tstate_t     m_state [NSLOT];
	logic [7:0]  m_prio  [NSLOT];
	logic [31:0] m_delay [NSLOT];
	logic [15:0] m_peak  [NSLOT];
	logic        m_listed[NSLOT];
	logic [3:0]  m_order [NSLOT];
	int unsigned m_count;
	logic [3:0]  m_run;
	logic        m_run_v;
	logic [15:0] m_rtime;
	logic [9:0]  m_tick;

	req_beat_t pending_reqs[$];
	answer_t   expected_answers[$];
	int        err_cnt;
	int        cyc;
	int        tx_gap;
	bit        quiet;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic void order_remove(input logic [3:0] s);
		int i;
		for (i = 0; i < int'(m_count); i++) begin
			if (m_order[i] == s) begin
				for (int j = i; j + 1 < int'(m_count); j++)
					m_order[j] = m_order[j + 1];
				m_count--;
				break;
			end
		end
		m_listed[s] = 1'b0;
	endfunction

	function automatic void order_insert(input logic [3:0] s);
		int p;
		p = 0;
		if (m_count >= NSLOT)
			return;
		while (p < int'(m_count) && m_prio[m_order[p]] <= m_prio[s])
			p++;
		for (int j = int'(m_count); j > p; j--)
			m_order[j] = m_order[j - 1];
		m_order[p] = s;
		m_count++;
		m_listed[s] = 1'b1;
	endfunction

	function automatic answer_t schedule_step(input req_beat_t b);
		answer_t    a;
		logic [3:0] s;
		logic [3:0] t;
		logic       rv;
		logic [3:0] rep;
		a = '0;
		s = b.slt;
		rv = 1'b1;
		rep = s;
		case (b.req)
			REQ_CREATE: begin
				if (m_listed[s]) begin
					a.stat = STAT_EXISTS;
				end else begin
					m_delay[s] = '0;
					m_state[s] = TS_READY;
					m_prio[s] = b.prio;
					order_insert(s);
				end
			end
			REQ_DELETE: begin
				m_state[s] = TS_TERM;
				if (m_listed[s])
					order_remove(s);
				else
					a.stat = STAT_NOT_FOUND;
			end
			REQ_DELAY, REQ_SUSPEND, REQ_RESUME, REQ_SETPRIO: begin
				if (m_state[s] == TS_TERM) begin
					a.stat = STAT_NOT_FOUND;
				end else if (b.req == REQ_DELAY) begin
					m_delay[s] = b.dly;
					m_state[s] = TS_DELAY;
				end else if (b.req == REQ_SUSPEND) begin
					m_state[s] = TS_SUSP;
				end else if (b.req == REQ_RESUME) begin
					m_state[s] = TS_READY;
				end else begin
					m_prio[s] = b.prio;
					order_remove(s);
					order_insert(s);
				end
			end
			REQ_PEND: begin
				if (!m_run_v || m_state[m_run] == TS_TERM)
					a.stat = STAT_NOT_FOUND;
				else
					m_state[m_run] = TS_PEND;
			end
			REQ_TICK: begin
				if (m_run_v)
					m_rtime = m_rtime + 16'(m_tick);
				for (int i = 0; i < int'(m_count); i++) begin
					t = m_order[i];
					if (m_state[t] == TS_DELAY) begin
						if (m_delay[t] == 0)
							m_state[t] = TS_READY;
						else if (m_delay[t] > 32'(m_tick))
							m_delay[t] = m_delay[t] - 32'(m_tick);
						else
							m_delay[t] = '0;
					end
				end
			end
			REQ_SCHED: begin
				m_run_v = 1'b0;
				a.stat = STAT_NONE_READY;
				for (int i = 0; i < int'(m_count); i++) begin
					t = m_order[i];
					if (m_state[t] == TS_READY || m_state[t] == TS_RUN ||
							(m_state[t] == TS_PEND && b.msg[t])) begin
						m_state[t] = TS_RUN;
						m_rtime = '0;
						m_run = t;
						m_run_v = 1'b1;
						a.stat = STAT_OK;
						a.gv = 1'b1;
						a.gs = t;
						break;
					end
				end
			end
			REQ_FINISH: begin
				if (!m_run_v) begin
					a.stat = STAT_NOT_FOUND;
				end else begin
					t = m_run;
					if (m_rtime > m_peak[t])
						m_peak[t] = m_rtime;
					if (m_state[t] == TS_RUN)
						m_state[t] = TS_READY;
					if (m_state[t] != TS_TERM) begin
						order_remove(t);
						order_insert(t);
					end
				end
			end
			default: ;
		endcase
		if (b.req == REQ_PEND || b.req == REQ_SCHED || b.req == REQ_FINISH) begin
			rv = m_run_v;
			rep = m_run;
		end
		if (rv) begin
			a.st = m_state[rep];
			a.pr = m_prio[rep];
			a.peak = m_peak[rep];
		end
		return a;
	endfunction

	// acceptance is sampled at the rising edge and drive updated at the fall
	logic took;
	always @(posedge clk) begin
		took <= arst_n && start && !busy;
	end

	// request driver, falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || took) begin
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				start <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				req_beat_t b;
				b = pending_reqs.pop_front();
				expected_answers.push_back(schedule_step(b));
				req_type <= b.req;
				slot <= b.slt;
				priority_req <= b.prio;
				delay_ms <= b.dly;
				msg_waiting <= b.msg;
				start <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0)
					tx_gap <= $urandom_range(1, 5);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// answer monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				$error("answer beat with nothing expected");
				err_cnt++;
			end else begin
				answer_t e;
				e = expected_answers.pop_front();
				if (status !== e.stat) begin
					$error("status exp %0d got %0d", e.stat, status); err_cnt++;
				end
				if (grant_valid !== e.gv) begin
					$error("grant_valid exp %0d got %0d", e.gv, grant_valid); err_cnt++;
				end
				if (granted_slot !== e.gs) begin
					$error("granted_slot exp %0d got %0d", e.gs, granted_slot); err_cnt++;
				end
				if (task_state !== e.st) begin
					$error("task_state exp %0d got %0d", e.st, task_state); err_cnt++;
				end
				if (task_priority !== e.pr) begin
					$error("task_priority exp %0d got %0d", e.pr, task_priority);
					err_cnt++;
				end
				if (run_peak_ms !== e.peak) begin
					$error("run_peak_ms exp %0d got %0d", e.peak, run_peak_ms);
					err_cnt++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYC_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic req_beat_t mk(input logic [3:0] r, input logic [3:0] s,
			input logic [7:0] p, input logic [31:0] d, input logic [15:0] m);
		req_beat_t b;
		b.req = r; b.slt = s; b.prio = p; b.dly = d; b.msg = m;
		return b;
	endfunction

	function automatic req_beat_t rand_req();
		req_beat_t b;
		int k;
		k = $urandom_range(0, 99);
		b.slt = $urandom_range(0, 5) == 0 ? 4'($urandom) : 4'($urandom_range(0, 5));
		b.prio = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3));
		b.dly = $urandom_range(0, 7) == 0 ? $urandom : 32'($urandom_range(0, 60));
		b.msg = 16'($urandom);
		if (k < 8) b.req = REQ_CREATE;
		else if (k < 13) b.req = REQ_DELETE;
		else if (k < 19) b.req = REQ_DELAY;
		else if (k < 23) b.req = REQ_SUSPEND;
		else if (k < 29) b.req = REQ_RESUME;
		else if (k < 33) b.req = REQ_SETPRIO;
		else if (k < 38) b.req = REQ_PEND;
		else if (k < 60) b.req = REQ_TICK;
		else if (k < 75) b.req = REQ_SCHED;
		else if (k < 88) b.req = REQ_FINISH;
		else if (k < 96) b.req = REQ_QUERY;
		else b.req = 4'($urandom_range(11, 15));
		return b;
	endfunction

	task automatic drain();
		while (pending_reqs.size() > 0 || expected_answers.size() > 0 || start)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_tick(input logic [9:0] v);
		@(negedge clk);
		tick_ms <= v;
		tick_ms_we <= 1'b1;
		m_tick = v;
		@(negedge clk);
		tick_ms_we <= 1'b0;
	endtask

	initial begin
		logic [9:0] ticks[4];
		start = 1'b0; req_type = '0; slot = '0; priority_req = '0; delay_ms = '0;
		msg_waiting = '0; tick_ms_we = 1'b0; tick_ms = TICK_RESET;
		took = 1'b0; tx_gap = 0; quiet = 0; err_cnt = 0; cyc = 0;
		for (int i = 0; i < NSLOT; i++) begin
			m_state[i] = TS_TERM; m_prio[i] = '0; m_delay[i] = '0; m_peak[i] = '0;
			m_listed[i] = 1'b0; m_order[i] = '0;
		end
		m_count = 0; m_run = '0; m_run_v = 1'b0; m_rtime = '0; m_tick = TICK_RESET;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty-table cases, extremes, every request code
		pending_reqs.push_back(mk(REQ_SCHED, 0, 0, 0, 16'hFFFF));
		pending_reqs.push_back(mk(REQ_PEND, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_FINISH, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_DELETE, 4'd15, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_DELAY, 4'd3, 0, 32'hFFFF_FFFF, 0));
		pending_reqs.push_back(mk(REQ_CREATE, 4'd15, 8'd255, 0, 0));
		pending_reqs.push_back(mk(REQ_CREATE, 4'd0, 8'd0, 0, 0));
		pending_reqs.push_back(mk(REQ_CREATE, 4'd0, 8'd7, 0, 0));
		pending_reqs.push_back(mk(REQ_CREATE, 4'd5, 8'd0, 0, 0));
		pending_reqs.push_back(mk(REQ_SCHED, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_TICK, 4'd2, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_FINISH, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_SCHED, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_PEND, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_SCHED, 0, 0, 0, 16'h0000));
		pending_reqs.push_back(mk(REQ_DELAY, 4'd0, 0, 32'hFFFF_FFFF, 0));
		pending_reqs.push_back(mk(REQ_SUSPEND, 4'd15, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_SCHED, 0, 0, 0, 16'hFFFF));
		pending_reqs.push_back(mk(REQ_RESUME, 4'd15, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_SETPRIO, 4'd15, 8'd0, 0, 0));
		pending_reqs.push_back(mk(REQ_DELETE, 4'd5, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_PEND, 0, 0, 0, 0));
		pending_reqs.push_back(mk(REQ_QUERY, 4'd9, 0, 0, 0));
		pending_reqs.push_back(mk(4'd15, 4'd1, 0, 0, 0));
		drain();

		// random phases over several tick settings
		ticks[0] = 10'd1; ticks[1] = 10'd1000; ticks[2] = 10'($urandom_range(2, 999));
		ticks[3] = 10'd1023;
		for (int ph = 0; ph < 4; ph++) begin
			set_tick(ticks[ph]);
			for (int n = 0; n < 410; n++)
				pending_reqs.push_back(rand_req());
			if (ph == 3)
				quiet = 1;
			drain();
		end

		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
